@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the SHA-256 hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_chain;

    typedef struct packed {
        logic  push;
        logic  init;
        t_word word;
    } t_core_ctl;

    typedef struct packed {
        logic       busy;
        logic [3:0] cnt;
    } t_core_sts;

    localparam int NumRounds  = 64;
    localparam int BlockWords = 16;

    localparam t_word RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // word 0 in the low slot
    localparam t_chain InitHash = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word PadWord = 32'h80000000;

    function automatic t_word big_s0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_s1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sml_s0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word sml_s1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word major(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

@@ rtl/core/sha_core.sv @@
// SHA-256 block buffer, message schedule and one-round-per-cycle compression.
`include "assert_macros.svh"

module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    output sha_pkg::t_core_sts o_sts,
    output sha_pkg::t_chain    o_chain
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]      r_state;
    logic [5:0]      r_round;
    logic [3:0]      r_cnt;
    sha_pkg::t_chain r_chain;
    sha_pkg::t_chain r_v;
    sha_pkg::t_word  r_w [sha_pkg::BlockWords];

    sha_pkg::t_word  w_sched;
    sha_pkg::t_word  t1;
    sha_pkg::t_word  t2;
    sha_pkg::t_chain v_next;

    always_comb begin
        w_sched = sha_pkg::sml_s1(r_w[14]) + r_w[9] + sha_pkg::sml_s0(r_w[1]) + r_w[0];
        t1 = r_v[7] + sha_pkg::big_s1(r_v[4]) + sha_pkg::choose(r_v[4], r_v[5], r_v[6])
           + sha_pkg::RoundK[r_round] + r_w[0];
        t2 = sha_pkg::big_s0(r_v[0]) + sha_pkg::major(r_v[0], r_v[1], r_v[2]);
        v_next[7] = r_v[6];
        v_next[6] = r_v[5];
        v_next[5] = r_v[4];
        v_next[4] = r_v[3] + t1;
        v_next[3] = r_v[2];
        v_next[2] = r_v[1];
        v_next[1] = r_v[0];
        v_next[0] = t1 + t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_cnt   <= '0;
            r_chain <= sha_pkg::InitHash;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.init) begin
                        r_chain <= sha_pkg::InitHash;
                    end
                    if (i_ctl.push) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_state <= ST_ROUND;
                            r_round <= '0;
                        end
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // schedule doubles as the block buffer: words enter at the top, w[t] leaves at slot 0
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.push) begin
            for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[sha_pkg::BlockWords - 1] <= i_ctl.word;
            r_v <= r_chain;
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[sha_pkg::BlockWords - 1] <= w_sched;
            r_v <= v_next;
        end
    end

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_sts.cnt  = r_cnt;
    assign o_chain    = r_chain;

    `ASSERT_CLK(a_no_push_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !i_ctl.push, "push while compressing")
    `ASSERT_CLK(a_round_end, i_clk, i_rst_n, (r_state == ST_ROUND && r_round == 6'd63) |=> (r_state == ST_ADD), "round count overrun")
    `ASSERT_CLK(a_add_done, i_clk, i_rst_n, (r_state == ST_ADD) |=> (r_state == ST_IDLE && r_cnt == 4'd0), "block count not aligned after compression")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE && r_cnt == 4'd0), "reset did not clear core")

endmodule

@@ rtl/core/sha256_message_hasher_unit.sv @@
// SHA-256 message hasher top level: input framing, padding sequencer, digest output.
//
// Usage: message words arrive on the slave stream, one request per word, first
// byte in tdata[31:24]; tdata[34:32] gives the valid byte count and tlast marks
// the final word. Each message returns eight digest words on the master stream,
// index in tdata[34:32], tlast on word 7.
// Throughput: a word is taken per cycle while the block buffer fills; the
// sixteenth word of a block starts a compression (64 rounds of the single
// round unit, then the chaining add) during which tready is low, so no word
// is taken until the compression ends.
// After the last word, two to eighteen padding pushes and one or two
// compressions run before the first digest word is offered, and the digest
// takes eight transfers.
// Reset clears the sequencer, the bit count and loads the initial hash; the
// block buffer needs no clearing. While the receiver stalls the digest word
// holds and no input is taken; after the eighth word the unit is ready for the
// next message.
`include "assert_macros.svh"

module sha256_message_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // data_word[31:0], valid_bytes[34:32], zero pad
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // digest_word[31:0], digest_index[34:32], zero pad
    output logic        o_m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic        r_need80;
    logic        r_len_hi;
    logic [63:0] r_bits;
    logic [2:0]  r_idx;

    sha_pkg::t_core_ctl ctl;
    sha_pkg::t_core_sts sts;
    sha_pkg::t_chain    chain;

    logic           in_acc;
    logic           out_acc;
    logic [2:0]     lane_cnt;
    logic [2:0]     add_bytes;
    sha_pkg::t_word data_w;
    sha_pkg::t_word last_w;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_chain (chain)
    );

    assign o_s_tready = (r_state == S_IDLE) && !sts.busy;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == S_OUT);
    assign out_acc    = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = {5'b0, r_idx, chain[r_idx]};
    assign o_m_tlast  = (r_idx == 3'd7);

    assign data_w    = i_s_tdata[31:0];
    assign lane_cnt  = i_s_tdata[34] ? 3'd4 : i_s_tdata[34:32];
    assign add_bytes = i_s_tlast ? lane_cnt : 3'd4;

    always_comb begin
        case (lane_cnt)
            3'd0:    last_w = sha_pkg::PadWord;
            3'd1:    last_w = {data_w[31:24], 24'h800000};
            3'd2:    last_w = {data_w[31:16], 16'h8000};
            3'd3:    last_w = {data_w[31:8], 8'h80};
            default: last_w = data_w;
        endcase
    end

    always_comb begin
        ctl.push = 1'b0;
        ctl.init = 1'b0;
        ctl.word = '0;
        unique case (r_state)
            S_IDLE: begin
                ctl.push = in_acc;
                ctl.word = i_s_tlast ? last_w : data_w;
            end
            S_PAD: begin
                ctl.push = !sts.busy;
                if (r_need80) begin
                    ctl.word = sha_pkg::PadWord;
                end else if (r_len_hi) begin
                    ctl.word = r_bits[31:0];
                end else if (sts.cnt == 4'd14) begin
                    ctl.word = r_bits[63:32];
                end
            end
            S_WAIT: begin
                ctl.push = 1'b0;
            end
            S_OUT: begin
                ctl.init = out_acc && (r_idx == 3'd7);
            end
            default: begin
                ctl.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_need80 <= 1'b0;
            r_len_hi <= 1'b0;
            r_bits   <= '0;
            r_idx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_bits <= r_bits + 64'({add_bytes, 3'b000});
                        if (i_s_tlast) begin
                            r_need80 <= (lane_cnt == 3'd4);
                            r_state  <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (!sts.busy) begin
                        if (r_need80) begin
                            r_need80 <= 1'b0;
                        end else if (r_len_hi) begin
                            r_len_hi <= 1'b0;
                            r_state  <= S_WAIT;
                        end else if (sts.cnt == 4'd14) begin
                            r_len_hi <= 1'b1;
                        end
                    end
                end
                S_WAIT: begin
                    if (!sts.busy) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_bits  <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_digest_done, i_clk, i_rst_n, (out_acc && r_idx == 3'd7) |=> (r_state == S_IDLE && r_bits == 64'd0 && sts.cnt == 4'd0), "state not cleared after digest")
    `ASSERT_CLK(a_block_aligned, i_clk, i_rst_n, (r_state == S_WAIT && !sts.busy) |-> (sts.cnt == 4'd0), "digest taken from a partial block")
    `ASSERT_CLK(a_pad_flag, i_clk, i_rst_n, r_need80 |-> (r_state == S_PAD), "pad flag outside padding")
    `ASSERT_CLK(a_len_slot, i_clk, i_rst_n, r_len_hi |-> (r_state == S_PAD && sts.cnt == 4'd15), "length low word out of place")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_idx)), "digest word dropped while stalled")

endmodule
